FILE: rtl/pvn_pkg.sv
// ----------------------------------------------------------------------------
// pvn_pkg
// Shared types, constants and helpers of the periodic value noise texel block.
// ----------------------------------------------------------------------------
package pvn_pkg;

    // default sizes
    localparam int MAX_SIZE_DEF        = 4096;
    localparam int FISSURE_OCT_DEF     = 4;
    localparam int GRAIN_OCT_DEF       = 2;

    // fixed-point formats: coordinates 24.16, fractions 0.16
    localparam int CW = 40;
    localparam int DW = 24;
    localparam int FW = 16;

    // pipeline depths
    localparam int CHAIN_LEN = DW;
    localparam int POST_LAT  = 7;
    localparam int OCT_LAT   = CHAIN_LEN + POST_LAT;
    localparam int LAYER_LAT = 2;

    // configuration register indexes
    localparam int          CFG_IDX_W           = 2;
    localparam int          CFG_DATA_W          = 13;
    localparam logic [1:0]  CFG_TEXTURE_SIZE    = 2'd0;
    localparam logic [1:0]  CFG_PALETTE_VARIANT = 2'd1;
    localparam logic [12:0] TEX_SIZE_RST        = 13'd256;

    // hash multipliers
    localparam logic [31:0] HASH_A = 32'd374761393;
    localparam logic [31:0] HASH_B = 32'd668265263;
    localparam logic [31:0] HASH_C = 32'd1274126177;

    // axis scales and offsets, 0.16 / 24.16
    localparam logic [15:0] K_012  = 16'd7864;
    localparam logic [15:0] K_003  = 16'd1966;
    localparam logic [15:0] K_HALF = 16'd32768;
    localparam logic [23:0] OFF_GX = 24'd2169242;
    localparam logic [23:0] OFF_GY = 24'd4712038;
    localparam logic [23:0] SEED_X = 24'd9771418;
    localparam logic [24:0] SEED_Y = 25'd17281843;

    // [palette][dark, mid, light][r, g, b], 0.16
    localparam logic [15:0] RAMP [4][3][3] = '{
        '{'{16'd6554,  16'd4588,  16'd2621},
          '{16'd13107, 16'd9175,  16'd5243},
          '{16'd20972, 16'd15073, 16'd9175}},
        '{'{16'd5898,  16'd5243,  16'd4588},
          '{16'd11141, 16'd9830,  16'd8520},
          '{16'd17695, 16'd15729, 16'd13763}},
        '{'{16'd8520,  16'd3932,  16'd1966},
          '{16'd17039, 16'd7864,  16'd3932},
          '{16'd24904, 16'd12452, 16'd7209}},
        '{'{16'd10486, 16'd9175,  16'd7864},
          '{16'd19661, 16'd17695, 16'd15073},
          '{16'd30147, 16'd27525, 16'd24248}}
    };

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } t_texel_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_texel_out;

    // a -> b by s, truncated toward a
    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] s);
        logic        up;
        logic [15:0] diff;
        logic [31:0] prod;
        up   = (b >= a);
        diff = up ? (b - a) : (a - b);
        prod = s * diff;
        return up ? (a + prod[31:16]) : (a - prod[31:16]);
    endfunction

endpackage

FILE: rtl/pvn_mod_cell.sv
// ----------------------------------------------------------------------------
// pvn_mod_cell
// One restoring remainder step for both lattice axes; fractions ride along.
// ----------------------------------------------------------------------------
module pvn_mod_cell #(
    parameter int PW = 17
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [PW-1:0]        i_px,
    input  logic [PW-1:0]        i_py,
    input  logic [PW-1:0]        i_rem_x,
    input  logic [PW-1:0]        i_rem_y,
    input  logic [pvn_pkg::DW-1:0] i_dvd_x,
    input  logic [pvn_pkg::DW-1:0] i_dvd_y,
    input  logic [pvn_pkg::FW-1:0] i_tx,
    input  logic [pvn_pkg::FW-1:0] i_ty,
    output logic [PW-1:0]        o_rem_x,
    output logic [PW-1:0]        o_rem_y,
    output logic [pvn_pkg::DW-1:0] o_dvd_x,
    output logic [pvn_pkg::DW-1:0] o_dvd_y,
    output logic [pvn_pkg::FW-1:0] o_tx,
    output logic [pvn_pkg::FW-1:0] o_ty
);
    import pvn_pkg::*;

    logic [PW:0]   w_trial_x, w_trial_y;
    logic [PW:0]   n_rem_x, n_rem_y;
    logic [PW-1:0] r_rem_x, r_rem_y;
    logic [DW-1:0] r_dvd_x, r_dvd_y;
    logic [FW-1:0] r_tx, r_ty;

    // remainder stays below the period, so one compare-subtract per bit
    assign w_trial_x = {i_rem_x, i_dvd_x[DW-1]};
    assign w_trial_y = {i_rem_y, i_dvd_y[DW-1]};
    assign n_rem_x = (w_trial_x >= {1'b0, i_px}) ? (w_trial_x - {1'b0, i_px}) : w_trial_x;
    assign n_rem_y = (w_trial_y >= {1'b0, i_py}) ? (w_trial_y - {1'b0, i_py}) : w_trial_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x <= n_rem_x[PW-1:0];
            r_rem_y <= n_rem_y[PW-1:0];
            r_dvd_x <= {i_dvd_x[DW-2:0], 1'b0};
            r_dvd_y <= {i_dvd_y[DW-2:0], 1'b0};
            r_tx    <= i_tx;
            r_ty    <= i_ty;
        end
    end

    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_dvd_x = r_dvd_x;
    assign o_dvd_y = r_dvd_y;
    assign o_tx    = r_tx;
    assign o_ty    = r_ty;

endmodule

FILE: rtl/pvn_octave.sv
// ----------------------------------------------------------------------------
// pvn_octave
// One noise octave: lattice wrap through a chain of remainder cells, corner
// hashing, smoothstep fade and bilinear blend.
// ----------------------------------------------------------------------------
module pvn_octave #(
    parameter int PW    = 17,
    parameter int SHIFT = 0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [pvn_pkg::CW-1:0] i_cx,
    input  logic [pvn_pkg::CW-1:0] i_cy,
    input  logic [PW-1:0]          i_px,
    input  logic [PW-1:0]          i_py,
    output logic [pvn_pkg::FW-1:0] o_noise
);
    import pvn_pkg::*;

    logic [CW-1:0] w_ox, w_oy;
    logic [PW-1:0] w_rem_x [0:CHAIN_LEN];
    logic [PW-1:0] w_rem_y [0:CHAIN_LEN];
    logic [DW-1:0] w_dvd_x [0:CHAIN_LEN-1];
    logic [DW-1:0] w_dvd_y [0:CHAIN_LEN-1];
    logic [FW-1:0] w_tx    [0:CHAIN_LEN];
    logic [FW-1:0] w_ty    [0:CHAIN_LEN];

    logic [PW:0]   w_inc_x, w_inc_y;
    logic [31:0]   w_sq_x, w_sq_y;
    logic [17:0]   w_wt_x, w_wt_y;
    logic [33:0]   w_fd_x, w_fd_y;
    logic [31:0]   w_pa [2];
    logic [31:0]   w_pb [2];
    logic [31:0]   w_h3 [4];
    logic [31:0]   w_h4 [4];
    logic [31:0]   w_h5 [4];

    logic [PW-1:0] r1_ax, r1_bx, r1_ay, r1_by;
    logic [FW-1:0] r1_t2x, r1_t2y, r1_tx, r1_ty;
    logic [31:0]   r2_pa [2];
    logic [31:0]   r2_pb [2];
    logic [FW-1:0] r2_sx, r2_sy, r3_sx, r3_sy, r4_sx, r4_sy, r5_sx, r5_sy, r6_sy;
    logic [31:0]   r3_h [4];
    logic [31:0]   r4_h [4];
    logic [FW-1:0] r5_v [4];
    logic [FW-1:0] r6_lo, r6_hi, r7_noise;

    assign w_ox = i_cx << SHIFT;
    assign w_oy = i_cy << SHIFT;

    assign w_rem_x[0] = '0;
    assign w_rem_y[0] = '0;
    assign w_dvd_x[0] = w_ox[CW-1:FW];
    assign w_dvd_y[0] = w_oy[CW-1:FW];
    assign w_tx[0]    = w_ox[FW-1:0];
    assign w_ty[0]    = w_oy[FW-1:0];

    for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
        if (k == CHAIN_LEN - 1) begin : g_last
            pvn_mod_cell #(.PW(PW)) u_cell (
                .i_clk  (i_clk),        .i_en   (i_en),
                .i_px   (i_px),         .i_py   (i_py),
                .i_rem_x(w_rem_x[k]),   .i_rem_y(w_rem_y[k]),
                .i_dvd_x(w_dvd_x[k]),   .i_dvd_y(w_dvd_y[k]),
                .i_tx   (w_tx[k]),      .i_ty   (w_ty[k]),
                .o_rem_x(w_rem_x[k+1]), .o_rem_y(w_rem_y[k+1]),
                .o_dvd_x(),             .o_dvd_y(),
                .o_tx   (w_tx[k+1]),    .o_ty   (w_ty[k+1])
            );
        end else begin : g_mid
            pvn_mod_cell #(.PW(PW)) u_cell (
                .i_clk  (i_clk),        .i_en   (i_en),
                .i_px   (i_px),         .i_py   (i_py),
                .i_rem_x(w_rem_x[k]),   .i_rem_y(w_rem_y[k]),
                .i_dvd_x(w_dvd_x[k]),   .i_dvd_y(w_dvd_y[k]),
                .i_tx   (w_tx[k]),      .i_ty   (w_ty[k]),
                .o_rem_x(w_rem_x[k+1]), .o_rem_y(w_rem_y[k+1]),
                .o_dvd_x(w_dvd_x[k+1]), .o_dvd_y(w_dvd_y[k+1]),
                .o_tx   (w_tx[k+1]),    .o_ty   (w_ty[k+1])
            );
        end
    end

    // neighbor corner wraps to zero at the period
    assign w_inc_x = {1'b0, w_rem_x[CHAIN_LEN]} + 1'b1;
    assign w_inc_y = {1'b0, w_rem_y[CHAIN_LEN]} + 1'b1;
    assign w_sq_x  = w_tx[CHAIN_LEN] * w_tx[CHAIN_LEN];
    assign w_sq_y  = w_ty[CHAIN_LEN] * w_ty[CHAIN_LEN];

    assign w_wt_x = 18'd196608 - {1'b0, r1_tx, 1'b0};
    assign w_wt_y = 18'd196608 - {1'b0, r1_ty, 1'b0};
    assign w_fd_x = r1_t2x * w_wt_x;
    assign w_fd_y = r1_t2y * w_wt_y;
    assign w_pa[0] = 32'(r1_ax) * HASH_A;
    assign w_pa[1] = 32'(r1_bx) * HASH_A;
    assign w_pb[0] = 32'(r1_ay) * HASH_B;
    assign w_pb[1] = 32'(r1_by) * HASH_B;

    // corner c: x side c[0], y side c[1]
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_h3[c] = r2_pa[c % 2] + r2_pb[c / 2];
            w_h4[c] = r3_h[c] * HASH_C;
            w_h5[c] = r4_h[c] ^ (r4_h[c] >> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax  <= w_rem_x[CHAIN_LEN];
            r1_ay  <= w_rem_y[CHAIN_LEN];
            r1_bx  <= (w_inc_x == {1'b0, i_px}) ? '0 : w_inc_x[PW-1:0];
            r1_by  <= (w_inc_y == {1'b0, i_py}) ? '0 : w_inc_y[PW-1:0];
            r1_t2x <= w_sq_x[31:16];
            r1_t2y <= w_sq_y[31:16];
            r1_tx  <= w_tx[CHAIN_LEN];
            r1_ty  <= w_ty[CHAIN_LEN];

            r2_pa  <= w_pa;
            r2_pb  <= w_pb;
            r2_sx  <= w_fd_x[31:16];
            r2_sy  <= w_fd_y[31:16];

            for (int c = 0; c < 4; c++) begin
                r3_h[c] <= w_h3[c] ^ (w_h3[c] >> 13);
                r4_h[c] <= w_h4[c];
                r5_v[c] <= w_h5[c][23:8];
            end
            r3_sx <= r2_sx;
            r3_sy <= r2_sy;
            r4_sx <= r3_sx;
            r4_sy <= r3_sy;
            r5_sx <= r4_sx;
            r5_sy <= r4_sy;

            r6_lo <= blend(r5_v[0], r5_v[1], r5_sx);
            r6_hi <= blend(r5_v[2], r5_v[3], r5_sx);
            r6_sy <= r5_sy;

            r7_noise <= blend(r6_lo, r6_hi, r6_sy);
        end
    end

    assign o_noise = r7_noise;

endmodule

FILE: rtl/pvn_layer.sv
// ----------------------------------------------------------------------------
// pvn_layer
// Weighted octave sum and normalization by 2^octaves - 1.
// ----------------------------------------------------------------------------
module pvn_layer #(
    parameter int OCTS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [OCTS-1:0][pvn_pkg::FW-1:0] i_noise,
    output logic [pvn_pkg::FW-1:0]           o_value
);
    import pvn_pkg::*;

    localparam int SUM_W = FW + OCTS;
    localparam int DIV   = (1 << OCTS) - 1;
    localparam int LG    = $clog2(DIV);
    localparam int SH    = SUM_W + LG;
    localparam int MW    = SUM_W + 1;
    // exact reciprocal for every sum below 2^SUM_W
    localparam longint unsigned MUL = ((64'd1 << SH) + DIV - 1) / DIV;

    logic [SUM_W-1:0]    n_sum, r_sum;
    logic [SUM_W+MW-1:0] w_prod;
    logic [FW-1:0]       r_value;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < OCTS; i++) begin
            n_sum = n_sum + (SUM_W'(i_noise[i]) << (OCTS - 1 - i));
        end
    end

    assign w_prod = r_sum * MW'(MUL);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= n_sum;
            r_value <= w_prod[SH +: FW];
        end
    end

    assign o_value = r_value;

endmodule

FILE: rtl/periodic_value_noise_texel.sv
// ----------------------------------------------------------------------------
// periodic_value_noise_texel
// Tileable bark texel: fissure and grain value-noise layers through a ramp.
// ----------------------------------------------------------------------------
// Input channel i_in_*: one request carries pixel_x / pixel_y. Output channel
// o_out_*: one RGB result per request, in request order. A request moves on a
// clock edge with valid high and stall low.
// Throughput: one pixel per clock unless the output stall holds the pipeline.
// Most of the depth is the per-octave wrap chain (one remainder cell per
// coordinate bit, 24 cells), followed by hashing, fade, blend, layer and ramp.
// If the output register holds a result and i_out_stall is high, the whole
// pipeline holds and o_in_stall is raised; bubbles do not collapse.
// Configuration: i_cfg_we writes texture_size (index 0) or palette_variant
// (index 1); other indexes are ignored. Write only while the pipeline is
// empty. Periods and seeds are registered from the written configuration.
// Reset (synchronous, active low) empties the pipeline, texture_size = 256,
// palette_variant = 0.
// ----------------------------------------------------------------------------
module periodic_value_noise_texel #(
    parameter int MAX_SIZE        = pvn_pkg::MAX_SIZE_DEF,
    parameter int FISSURE_OCTAVES = pvn_pkg::FISSURE_OCT_DEF,
    parameter int GRAIN_OCTAVES   = pvn_pkg::GRAIN_OCT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  pvn_pkg::t_texel_in            i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output pvn_pkg::t_texel_out           o_out_data,
    input  logic                          i_out_stall,
    input  logic                          i_cfg_we,
    input  logic [pvn_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pvn_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import pvn_pkg::*;

    localparam int SW   = $clog2(MAX_SIZE + 1);
    localparam int MAXO = (FISSURE_OCTAVES > GRAIN_OCTAVES) ? FISSURE_OCTAVES : GRAIN_OCTAVES;
    localparam int PW   = SW + MAXO;
    localparam int PRW  = PW + 16;
    localparam int NV   = 2 + OCT_LAT + LAYER_LAT + 2;

    function automatic logic [PW-1:0] f_period(input logic [SW-1:0] size,
                                               input logic [15:0] k, input int oct);
        logic [PRW-1:0] prod;
        logic [PW-1:0]  per;
        prod = ((PRW'(size) * PRW'(k)) << oct) + PRW'(32768);
        per  = prod[PRW-1:16];
        return (per == '0) ? PW'(1) : per;
    endfunction

    logic          w_en, w_accept;
    logic [NV-1:0] r_vld;
    logic          r_out_valid;
    t_texel_out    r_out;

    logic [12:0]   r_tex_size;
    logic [7:0]    r_variant;
    logic [31:0]   w_size_w;
    logic [SW-1:0] w_size;
    logic [31:0]   r_seed_x;
    logic [32:0]   r_seed_y;
    logic [PW-1:0] r_per_fx [FISSURE_OCTAVES];
    logic [PW-1:0] r_per_fy [FISSURE_OCTAVES];
    logic [PW-1:0] r_per_gx [GRAIN_OCTAVES];
    logic [PW-1:0] r_per_gy [GRAIN_OCTAVES];

    t_texel_in     r_in;
    logic [27:0]   w_mul_fx, w_mul_fy;
    logic [CW-1:0] r_fx, r_fy, r_gx, r_gy;

    logic [FISSURE_OCTAVES-1:0][FW-1:0] w_fis_n;
    logic [GRAIN_OCTAVES-1:0][FW-1:0]   w_grn_n;
    logic [FW-1:0] w_fis, w_grn;
    logic [17:0]   w_mix;
    logic [FW-1:0] r_ramp_s;
    logic          r_upper;
    logic [FW-1:0] r_col [3];
    logic [23:0]   w_byte [3];

    assign w_en       = !(r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && w_en;
    assign o_in_stall = !w_en;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_size <= TEX_SIZE_RST;
            r_variant  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEXTURE_SIZE:    r_tex_size <= i_cfg_wdata[12:0];
                CFG_PALETTE_VARIANT: r_variant  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign w_size_w = (32'(r_tex_size) > 32'(MAX_SIZE)) ? 32'(MAX_SIZE) : 32'(r_tex_size);
    assign w_size   = w_size_w[SW-1:0];

    always_ff @(posedge i_clk) begin
        r_seed_x <= 32'(r_variant) * 32'(SEED_X);
        r_seed_y <= 33'(r_variant) * 33'(SEED_Y);
        for (int i = 0; i < FISSURE_OCTAVES; i++) begin
            r_per_fx[i] <= f_period(w_size, K_012, i);
            r_per_fy[i] <= f_period(w_size, K_003, i);
        end
        for (int i = 0; i < GRAIN_OCTAVES; i++) begin
            r_per_gx[i] <= f_period(w_size, K_HALF, i);
            r_per_gy[i] <= f_period(w_size, K_HALF, i);
        end
    end

    // ---------------- request control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[NV-2:0], w_accept};
            r_out_valid <= r_vld[NV-1];
        end
    end

    // ---------------- coordinates ----------------
    assign w_mul_fx = 28'(r_in.pixel_x) * 28'(K_012);
    assign w_mul_fy = 28'(r_in.pixel_y) * 28'(K_003);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_in_data;
            r_fx <= CW'(w_mul_fx) + CW'(r_seed_x);
            r_fy <= CW'(w_mul_fy) + CW'(r_seed_y);
            r_gx <= CW'({r_in.pixel_x, 15'b0}) + CW'(OFF_GX) + CW'(r_seed_x);
            r_gy <= CW'({r_in.pixel_y, 15'b0}) + CW'(OFF_GY) + CW'(r_seed_y);
        end
    end

    // ---------------- octaves and layers ----------------
    for (genvar i = 0; i < FISSURE_OCTAVES; i++) begin : g_fis
        pvn_octave #(.PW(PW), .SHIFT(i)) u_oct (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cx   (r_fx),
            .i_cy   (r_fy),
            .i_px   (r_per_fx[i]),
            .i_py   (r_per_fy[i]),
            .o_noise(w_fis_n[i])
        );
    end

    for (genvar i = 0; i < GRAIN_OCTAVES; i++) begin : g_grn
        pvn_octave #(.PW(PW), .SHIFT(i)) u_oct (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cx   (r_gx),
            .i_cy   (r_gy),
            .i_px   (r_per_gx[i]),
            .i_py   (r_per_gy[i]),
            .o_noise(w_grn_n[i])
        );
    end

    pvn_layer #(.OCTS(FISSURE_OCTAVES)) u_fis_layer (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_noise(w_fis_n),
        .o_value(w_fis)
    );

    pvn_layer #(.OCTS(GRAIN_OCTAVES)) u_grn_layer (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_noise(w_grn_n),
        .o_value(w_grn)
    );

    // ---------------- mix, ramp, bytes ----------------
    assign w_mix = 18'(w_fis) + 18'({w_fis, 1'b0}) + 18'(w_grn);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_byte[c] = {r_col[c], 8'b0} - 24'(r_col[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // t < 0.5: dark->mid by 2t, else mid->light by 2(t-0.5)
            r_ramp_s <= {w_mix[16:2], 1'b0};
            r_upper  <= w_mix[17];
            for (int c = 0; c < 3; c++) begin
                r_col[c] <= r_upper
                    ? blend(RAMP[r_variant[1:0]][1][c], RAMP[r_variant[1:0]][2][c], r_ramp_s)
                    : blend(RAMP[r_variant[1:0]][0][c], RAMP[r_variant[1:0]][1][c], r_ramp_s);
            end
            r_out.red   <= w_byte[0][23:16];
            r_out.green <= w_byte[1][23:16];
            r_out.blue  <= w_byte[2][23:16];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_vld))
        else $error("pipeline advanced while output stalled");

    a_result_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vld[NV-1]))
        else $error("result appeared without a request at the last stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted request not tracked");

endmodule
